// ===== src/sc3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc3_pkg
// Shared constants for the separable 3x3 valid-region convolution block:
// register indexes, mode codes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package sc3_pkg;

    // Parameter defaults.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    // Fixed field widths.
    localparam int PIX_FIELD_W = 16;
    localparam int COEF_W      = 16;
    localparam int OUT_W       = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MODE_W      = 2;
    localparam int IMG_W_W     = 11;
    localparam int ROW_W       = 2;
    localparam int FRAC_BITS   = 12;

    typedef logic signed [COEF_W-1:0] t_coef;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_X0 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_X1 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_X2 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_Y0 = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_Y1 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_Y2 = 3'd7;

    // Mode codes. The unused code behaves as MODE_BOTH.
    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HORZ = 2'd2;

    // Reset values.
    localparam logic [IMG_W_W-1:0] RST_WIDTH   = 11'd1024;
    localparam t_coef              RST_COEF_X0 = -16'sd4096;
    localparam t_coef              RST_COEF_X1 = 16'sd0;
    localparam t_coef              RST_COEF_X2 = 16'sd4096;
    localparam t_coef              RST_COEF_Y0 = 16'sd0;
    localparam t_coef              RST_COEF_Y1 = 16'sd4096;
    localparam t_coef              RST_COEF_Y2 = 16'sd0;

endpackage

// ===== src/sep_conv3x3_valid_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep_conv3x3_valid_unit
// Streaming separable 3x3 convolution over the valid region, with two line
// stores in block memory and a single shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// The block takes one pixel item at a time and the next only once the last is
// through: it accepts the item and reads both line stores at its column, then
// the single multiply-accumulate unit works through the three vertical and the
// three horizontal taps, and a final step rounds (combined mode), saturates and
// hands the result to the output register. The shared multiplier sets the item
// rate. A finished result waits in the output register while the next item is
// accepted; the block only holds back at its last step when a new result is
// ready and the previous one has not been taken. Line store entries are written
// back in the cycle after the read, so the next item's read always sees them.
// Configuration may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module sep_conv3x3_valid_unit
    import sc3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Pixel input.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [PIX_FIELD_W-1:0] i_s_tdata,   // [15:0] pixel
    input  logic                   i_s_tuser,   // [0] frame_start
    // Result output.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_W-1:0]       o_m_tdata,   // [31:0] filtered
    output logic                   o_m_tlast    // row_end
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int WCMP_W = (CNT_W + 1 > IMG_W_W) ? CNT_W + 1 : IMG_W_W;
    localparam int V_W    = PIXEL_BITS + 18;   // vertical sum, 12 fraction bits
    localparam int PROD_W = COEF_W + V_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_V0   = 3'd1;
    localparam logic [2:0] ST_V1   = 3'd2;
    localparam logic [2:0] ST_V2   = 3'd3;
    localparam logic [2:0] ST_H0   = 3'd4;
    localparam logic [2:0] ST_H1   = 3'd5;
    localparam logic [2:0] ST_H2   = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    // Configuration registers.
    logic [MODE_W-1:0]  r_mode;
    logic [IMG_W_W-1:0] r_image_width;
    t_coef r_coef_x0, r_coef_x1, r_coef_x2;
    t_coef r_coef_y0, r_coef_y1, r_coef_y2;

    // Control state.
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_column_count;
    logic [ROW_W-1:0] r_row_count;
    logic             r_out_valid;

    // Per-item payload.
    logic [CNT_W-1:0]             r_col;
    logic [ROW_W-1:0]             r_row;
    logic                         r_last;
    logic signed [PIXEL_BITS-1:0] r_pix;
    logic signed [PIXEL_BITS-1:0] r_rd_a;   // row above
    logic signed [PIXEL_BITS-1:0] r_rd_b;   // row two above
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [V_W-1:0]        r_v;
    logic signed [V_W-1:0]        r_vp0, r_vp1;
    logic [OUT_W-1:0]             r_out_data;
    logic                         r_out_last;

    // Line stores.
    logic [PIXEL_BITS-1:0] mem_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] mem_b [MAX_WIDTH];

    logic                         w_s_acc;
    logic [CNT_W-1:0]             w_col_eff;
    logic [ROW_W-1:0]             w_row_eff;
    logic [WCMP_W-1:0]            w_width;
    logic                         w_last;
    logic signed [PIXEL_BITS-1:0] w_pix;
    t_coef                        w_mc;
    logic signed [V_W-1:0]        w_mo;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [ACC_W-1:0]      w_prod_ext;
    logic signed [ACC_W-1:0]      w_round;
    logic signed [ACC_W-1:0]      w_sel;
    logic [OUT_W-1:0]             w_sat;
    logic                         w_emit;
    logic                         w_fin_go;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_BOTH;
            r_image_width <= RST_WIDTH;
            r_coef_x0     <= RST_COEF_X0;
            r_coef_x1     <= RST_COEF_X1;
            r_coef_x2     <= RST_COEF_X2;
            r_coef_y0     <= RST_COEF_Y0;
            r_coef_y1     <= RST_COEF_Y1;
            r_coef_y2     <= RST_COEF_Y2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MODE:    r_mode        <= i_cfg_wdata[MODE_W-1:0];
                REG_WIDTH:   r_image_width <= i_cfg_wdata[IMG_W_W-1:0];
                REG_COEF_X0: r_coef_x0     <= t_coef'(i_cfg_wdata);
                REG_COEF_X1: r_coef_x1     <= t_coef'(i_cfg_wdata);
                REG_COEF_X2: r_coef_x2     <= t_coef'(i_cfg_wdata);
                REG_COEF_Y0: r_coef_y0     <= t_coef'(i_cfg_wdata);
                REG_COEF_Y1: r_coef_y1     <= t_coef'(i_cfg_wdata);
                REG_COEF_Y2: r_coef_y2     <= t_coef'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- input decoding
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_pix      = PIXEL_BITS'(i_s_tdata);

    assign w_col_eff = i_s_tuser ? '0 : r_column_count;
    assign w_row_eff = i_s_tuser ? '0 : r_row_count;

    always_comb begin
        if (WCMP_W'(r_image_width) < WCMP_W'(3)) begin
            w_width = WCMP_W'(3);
        end else if (WCMP_W'(r_image_width) > WCMP_W'(MAX_WIDTH)) begin
            w_width = WCMP_W'(MAX_WIDTH);
        end else begin
            w_width = WCMP_W'(r_image_width);
        end
    end

    assign w_last = (WCMP_W'(w_col_eff) + WCMP_W'(1)) >= w_width;

    // -------------------------------------------------------- line stores
    // Read at accept; write back in ST_V0 at the same column.
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_rd_a <= mem_a[w_col_eff];
            r_rd_b <= mem_b[w_col_eff];
        end
        if (r_state == ST_V0) begin
            mem_a[r_col] <= r_pix;
            mem_b[r_col] <= r_rd_a;
        end
    end

    // ------------------------------------------------- multiply-accumulate
    always_comb begin
        case (r_state)
            ST_V0: begin
                w_mc = r_coef_y0;
                w_mo = V_W'(r_rd_b);
            end
            ST_V1: begin
                w_mc = r_coef_y1;
                w_mo = V_W'(r_rd_a);
            end
            ST_V2: begin
                w_mc = r_coef_y2;
                w_mo = V_W'(r_pix);
            end
            ST_H0: begin
                w_mc = r_coef_x0;
                w_mo = r_vp0;
            end
            ST_H1: begin
                w_mc = r_coef_x1;
                w_mo = r_vp1;
            end
            ST_H2: begin
                w_mc = r_coef_x2;
                w_mo = (r_mode == MODE_HORZ) ? V_W'(r_pix) : r_v;
            end
            default: begin
                w_mc = '0;
                w_mo = '0;
            end
        endcase
    end

    assign w_prod     = w_mc * w_mo;
    assign w_prod_ext = ACC_W'(w_prod);

    // ------------------------------------------------ round and saturate
    // Ties round toward plus infinity: add one half, then shift arithmetically.
    assign w_round = (r_acc + ACC_W'(2048)) >>> FRAC_BITS;

    always_comb begin
        if (r_mode == MODE_VERT) begin
            w_sel = ACC_W'(r_v);
        end else if (r_mode == MODE_HORZ) begin
            w_sel = r_acc;
        end else begin
            w_sel = w_round;
        end
    end

    // The value fits in 32 bits when every bit above bit 30 equals the sign.
    always_comb begin
        if (&w_sel[ACC_W-1:OUT_W-1] || ~|w_sel[ACC_W-1:OUT_W-1]) begin
            w_sat = w_sel[OUT_W-1:0];
        end else if (w_sel[ACC_W-1]) begin
            w_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_comb begin
        if (r_mode == MODE_VERT) begin
            w_emit = (r_row >= ROW_W'(2));
        end else if (r_mode == MODE_HORZ) begin
            w_emit = (r_col >= CNT_W'(2));
        end else begin
            w_emit = (r_row >= ROW_W'(2)) && (r_col >= CNT_W'(2));
        end
    end

    // Hold in ST_FIN only while a new result would overwrite an untaken one.
    assign w_fin_go = !(w_emit && r_out_valid && !i_m_tready);

    // --------------------------------------------------------- sequencer
    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = w_s_acc ? ST_V0 : ST_IDLE;
            ST_V0:   n_state = ST_V1;
            ST_V1:   n_state = ST_V2;
            ST_V2:   n_state = ST_H0;
            ST_H0:   n_state = ST_H1;
            ST_H1:   n_state = ST_H2;
            ST_H2:   n_state = ST_FIN;
            ST_FIN:  n_state = w_fin_go ? ST_IDLE : ST_FIN;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_column_count <= '0;
            r_row_count    <= '0;
            r_vp0          <= '0;
            r_vp1          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_s_acc) begin
                if (w_last) begin
                    r_column_count <= '0;
                    r_row_count    <= (w_row_eff < ROW_W'(2)) ? w_row_eff + ROW_W'(1)
                                                              : w_row_eff;
                end else begin
                    r_column_count <= w_col_eff + CNT_W'(1);
                    r_row_count    <= w_row_eff;
                end
            end
            if (r_state == ST_FIN && w_fin_go) begin
                r_vp0 <= r_vp1;
                r_vp1 <= (r_mode == MODE_HORZ) ? V_W'(r_pix) : r_v;
            end
            if (r_state == ST_FIN && w_fin_go && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_col  <= w_col_eff;
            r_row  <= w_row_eff;
            r_last <= w_last;
            r_pix  <= w_pix;
        end
        case (r_state)
            ST_V0, ST_H0: r_acc <= w_prod_ext;
            ST_V1, ST_V2, ST_H1, ST_H2: r_acc <= r_acc + w_prod_ext;
            default: ;
        endcase
        if (r_state == ST_H0) begin
            r_v <= r_acc[V_W-1:0];
        end
        if (r_state == ST_FIN && w_fin_go && w_emit) begin
            r_out_data <= w_sat;
            r_out_last <= r_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // -------------------------------------------------------- assertions
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column_count < CNT_W'(MAX_WIDTH - 1) || r_column_count == CNT_W'(MAX_WIDTH - 1))
        else $error("column counter beyond the line store depth");

    a_row_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_count <= ROW_W'(2))
        else $error("row counter passed its saturation point");

    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |-> ##7 (r_state == ST_FIN))
        else $error("item did not reach the final step seven cycles after accept");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && w_last) |=> (r_column_count == '0))
        else $error("column counter did not wrap at the end of a row");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && w_emit && r_out_valid && !i_m_tready)
            |=> (r_state == ST_FIN))
        else $error("result left the final step while the output was still full");

endmodule

// ===== tb/sv/sep_conv3x3_valid_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep_conv3x3_valid_unit_test
// Self-checking bench for the separable 3x3 valid-region convolution. Pixels
// are streamed in raster order with random gaps and output stalls. Every
// accepted pixel is run through an in-bench model of the filter, and every
// result is checked against the oldest expected value. A few directed frames
// cover field extremes, saturation, rounding ties and all modes. Random phases
// then change the configuration between frames; directed frames before them
// also take an oversized width and a width cut short in the middle of a row.
// ----------------------------------------------------------------------------
module sep_conv3x3_valid_unit_test;
    import sc3_pkg::*;

    // The spare mode code behaves as MODE_BOTH.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] COEF_REGS [6] = '{
        REG_COEF_X0, REG_COEF_X1, REG_COEF_X2, REG_COEF_Y0, REG_COEF_Y1, REG_COEF_Y2
    };
    localparam int RANDOM_ITEMS = 650;

    typedef struct packed {
        logic [OUT_W-1:0] filtered;
        logic             row_end;
    } conv_out_t;

    class filter_scoreboard;
        localparam longint SAT_HI = 64'sd2147483647;
        localparam longint SAT_LO = -64'sd2147483648;

        logic [MODE_W-1:0]  mode;
        logic [IMG_W_W-1:0] width_reg;
        longint             tap_x [3];
        longint             tap_y [3];
        longint             row_above [DEF_MAX_WIDTH];
        longint             row_two_up [DEF_MAX_WIDTH];
        longint             prev_col [2];
        int                 next_col;
        int                 rows_done;
        conv_out_t          due_outputs [$];
        int                 errors;
        int                 pixels;
        int                 results;
        int                 row_ends;

        function new();
            mode = MODE_BOTH;
            width_reg = RST_WIDTH;
            tap_x[0] = RST_COEF_X0;
            tap_x[1] = RST_COEF_X1;
            tap_x[2] = RST_COEF_X2;
            tap_y[0] = RST_COEF_Y0;
            tap_y[1] = RST_COEF_Y1;
            tap_y[2] = RST_COEF_Y2;
            foreach (row_above[i]) begin
                row_above[i] = 0;
                row_two_up[i] = 0;
            end
            prev_col[0] = 0;
            prev_col[1] = 0;
            next_col = 0;
            rows_done = 0;
            errors = 0;
            pixels = 0;
            results = 0;
            row_ends = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MODE:    mode = val[MODE_W-1:0];
                REG_WIDTH:   width_reg = val[IMG_W_W-1:0];
                REG_COEF_X0: tap_x[0] = longint'($signed(val));
                REG_COEF_X1: tap_x[1] = longint'($signed(val));
                REG_COEF_X2: tap_x[2] = longint'($signed(val));
                REG_COEF_Y0: tap_y[0] = longint'($signed(val));
                REG_COEF_Y1: tap_y[1] = longint'($signed(val));
                REG_COEF_Y2: tap_y[2] = longint'($signed(val));
                default: ;
            endcase
        endfunction

        function int row_len();
            int w;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
            return w;
        endfunction

        function logic [OUT_W-1:0] clamp32(longint x);
            if (x > SAT_HI) return SAT_HI[OUT_W-1:0];
            if (x < SAT_LO) return SAT_LO[OUT_W-1:0];
            return x[OUT_W-1:0];
        endfunction

        function int outstanding();
            return due_outputs.size();
        endfunction

        task flag(string msg);
            errors++;
            if (errors <= 30) $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        function void take_pixel(logic [PIX_FIELD_W-1:0] pix, logic frame_start);
            int        c;
            bit        last;
            bit        emit;
            longint    p;
            longint    top;
            longint    mid;
            longint    v;
            longint    s;
            conv_out_t e;
            pixels++;
            if (frame_start) begin
                next_col = 0;
                rows_done = 0;
            end
            c = next_col;
            if (c >= DEF_MAX_WIDTH) c = 0;
            last = (c + 1 >= row_len());
            p = longint'($signed(pix));
            top = row_two_up[c];
            mid = row_above[c];
            row_two_up[c] = mid;
            row_above[c] = p;
            v = tap_y[0] * top + tap_y[1] * mid + tap_y[2] * p;
            emit = 1'b0;
            case (mode)
                MODE_VERT: begin
                    if (rows_done >= 2) begin
                        e.filtered = clamp32(v);
                        emit = 1'b1;
                    end
                end
                MODE_HORZ: begin
                    if (c >= 2) begin
                        s = tap_x[0] * prev_col[0] + tap_x[1] * prev_col[1] + tap_x[2] * p;
                        e.filtered = clamp32(s);
                        emit = 1'b1;
                    end
                end
                default: begin
                    if (rows_done >= 2 && c >= 2) begin
                        s = tap_x[0] * prev_col[0] + tap_x[1] * prev_col[1] + tap_x[2] * v;
                        // Round half up: 24 fractional bits down to 12.
                        e.filtered = clamp32((s + 2048) >>> FRAC_BITS);
                        emit = 1'b1;
                    end
                end
            endcase
            prev_col[0] = prev_col[1];
            prev_col[1] = (mode == MODE_HORZ) ? p : v;
            if (last) begin
                next_col = 0;
                if (rows_done < 2) rows_done++;
            end else begin
                next_col = c + 1;
            end
            if (emit) begin
                e.row_end = last;
                due_outputs.push_back(e);
            end
        endfunction

        task check_output(logic [OUT_W-1:0] filtered, logic row_end);
            conv_out_t e;
            results++;
            if (due_outputs.size() == 0) begin
                flag($sformatf("result %h with nothing expected", filtered));
                return;
            end
            e = due_outputs.pop_front();
            if (e.row_end) row_ends++;
            if (filtered !== e.filtered)
                flag($sformatf("result %0d: filtered %h, expected %h",
                               results, filtered, e.filtered));
            if (row_end !== e.row_end)
                flag($sformatf("result %0d: row_end %b, expected %b",
                               results, row_end, e.row_end));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = REG_MODE;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic [PIX_FIELD_W-1:0] s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_W-1:0]       o_m_tdata;
    logic                   o_m_tlast;

    bit               calm = 1'b1;
    int               sink_hold = 0;
    int               configs = 0;
    filter_scoreboard sb = new();

    sep_conv3x3_valid_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Both handshakes are sampled with the values that held before the edge.
    always @(posedge i_clk) begin
        if (rst_n && s_tvalid && o_s_tready === 1'b1) sb.take_pixel(s_tdata, s_tuser);
        if (rst_n && o_m_tvalid === 1'b1 && m_tready) sb.check_output(o_m_tdata, o_m_tlast);
    end

    always @(posedge i_clk) begin : sink_pace
        int roll;
        if (calm) begin
            m_tready <= 1'b1;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                m_tready <= 1'b1;
                sink_hold <= $urandom_range(0, 6);
            end else if (roll < 92) begin
                m_tready <= 1'b0;
                sink_hold <= $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                sink_hold <= $urandom_range(8, 40);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_FIELD_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3: return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h1000;
            4: return 16'hf000;
            5, 6: return 16'($urandom_range(0, 16384) - 8192);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [PIX_FIELD_W-1:0] pix, input logic frame_start);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= frame_start;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
    endtask

    // Holds the input back until every expected result has been taken.
    task automatic hold_until_empty();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.outstanding() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Items that make no result may still be in the pipeline, so allow a few
    // item times before touching the registers.
    task automatic settle();
        hold_until_empty();
        repeat (24) @(posedge i_clk);
    endtask

    task automatic program_random();
        logic [CFG_DATA_W-1:0] val;
        int                    roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) val = 16'($urandom_range(0, 2));
        else if (roll < 75) val = 16'($urandom_range(3, 10));
        else if (roll < 95) val = 16'($urandom_range(11, 40));
        else val = 16'($urandom_range(41, 100));
        if ($urandom_range(0, 3) == 0) val[CFG_DATA_W-1:IMG_W_W] = 5'($urandom);
        write_reg(REG_WIDTH, val);
        val = 16'($urandom);
        case ($urandom_range(0, 7))
            0, 1, 2: val[MODE_W-1:0] = MODE_BOTH;
            3, 4:    val[MODE_W-1:0] = MODE_VERT;
            5, 6:    val[MODE_W-1:0] = MODE_HORZ;
            default: val[MODE_W-1:0] = MODE_SPARE;
        endcase
        if ($urandom_range(0, 1)) val[CFG_DATA_W-1:MODE_W] = '0;
        write_reg(REG_MODE, val);
        foreach (COEF_REGS[i])
            if ($urandom_range(0, 1)) write_reg(COEF_REGS[i], pick_coef());
        configs++;
    endtask

    initial begin
        int rows;
        int stop;
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Horizontal only, width below the minimum, taps at the extremes:
        // both rows saturate, one high and one low.
        write_reg(REG_MODE, 16'(MODE_HORZ));
        write_reg(REG_WIDTH, 16'h0000);
        write_reg(REG_COEF_X0, 16'h8000);
        write_reg(REG_COEF_X1, 16'h7fff);
        write_reg(REG_COEF_X2, 16'h8000);
        send_pixel(16'h8000, 1'b1);
        send_pixel(16'h7fff, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h7fff, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h7fff, 1'b0);
        settle();

        // Vertical only over three rows of three.
        write_reg(REG_MODE, 16'(MODE_VERT));
        write_reg(REG_WIDTH, 16'd3);
        write_reg(REG_COEF_Y0, 16'h8000);
        write_reg(REG_COEF_Y1, 16'h7fff);
        write_reg(REG_COEF_Y2, 16'h8000);
        send_pixel(16'h8000, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h7fff, 1'b0);
        send_pixel(16'h7fff, 1'b0);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'h7fff, 1'b0);
        settle();

        // Spare mode code with taps picked so that the rounding hits exact
        // halves, one positive and one negative.
        write_reg(REG_MODE, 16'(MODE_SPARE));
        write_reg(REG_COEF_Y0, 16'h0000);
        write_reg(REG_COEF_Y1, 16'h0001);
        write_reg(REG_COEF_Y2, 16'h0000);
        write_reg(REG_COEF_X0, 16'h0000);
        write_reg(REG_COEF_X1, 16'h0000);
        write_reg(REG_COEF_X2, 16'h0800);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0005, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'h0007, 1'b0);
        send_pixel(16'h0007, 1'b0);
        send_pixel(16'h0007, 1'b0);
        settle();

        // A width above the maximum, then cut down while the row is open, so
        // the next item closes the row early.
        calm = 1'b0;
        write_reg(REG_MODE, 16'(MODE_HORZ));
        write_reg(REG_WIDTH, 16'hffff);
        foreach (COEF_REGS[i]) write_reg(COEF_REGS[i], pick_coef());
        for (int k = 0; k < 40; k++) send_pixel(pick_pixel(), k == 0);
        settle();
        write_reg(REG_WIDTH, 16'd5);
        for (int k = 0; k < 16; k++) send_pixel(pick_pixel(), 1'b0);
        settle();

        while (sb.pixels < RANDOM_ITEMS) begin
            program_random();
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 2)) begin
                rows = (sb.row_len() <= 10) ? $urandom_range(3, 6) : $urandom_range(3, 4);
                stop = rows * sb.row_len();
                // Now and then a frame is cut off before its end.
                if ($urandom_range(0, 6) == 0) stop = $urandom_range(1, stop - 1);
                for (int k = 0; k < stop && sb.pixels < RANDOM_ITEMS; k++) begin
                    if ($urandom_range(0, 59) == 0) hold_until_empty();
                    send_pixel(pick_pixel(), k == 0 || $urandom_range(0, 49) == 0);
                end
            end
            settle();
        end

        $display("Streamed %0d pixel items over %0d random configurations plus directed frames.",
                 sb.pixels, configs);
        $display("Checked %0d results, %0d of them closing a row, in all four mode codes.",
                 sb.results, sb.row_ends);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches found.", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timed out with %0d results outstanding.", sb.outstanding());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/sc3_pkg.sv
src/sep_conv3x3_valid_unit.sv
tb/sv/sep_conv3x3_valid_unit_test.sv
